FILE: hw/rtl/hse_pkg.sv
// Shared types and constants for the heap sort engine.
package hse_pkg;

  localparam int HSE_DEPTH = 64;
  localparam int VAL_W     = 32;

  typedef logic signed [VAL_W-1:0] val_t;

endpackage

FILE: hw/rtl/hse_store.sv
// Element store: one write port, one read port with registered read data.
module hse_store #(
  parameter int DEPTH = hse_pkg::HSE_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  hse_pkg::val_t  wdata,
  input  logic [AW-1:0]  raddr,
  output hse_pkg::val_t  rdata
);
  import hse_pkg::*;

  val_t mem [DEPTH];
  val_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/hse_ctrl.sv
// Sequencer: loads the batch, runs heapsort on the store, streams results out.
module hse_ctrl #(
  parameter int DEPTH = hse_pkg::HSE_DEPTH,
  parameter int AW    = $clog2(DEPTH),
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  hse_pkg::val_t  in_value,
  input  logic           in_tlast,
  output logic           out_tvalid,
  input  logic           out_tready,
  output hse_pkg::val_t  out_value,
  output logic           out_tlast,
  output logic           out_tuser,
  output logic           mem_we,
  output logic [AW-1:0]  mem_waddr,
  output hse_pkg::val_t  mem_wdata,
  output logic [AW-1:0]  mem_raddr,
  input  hse_pkg::val_t  mem_rdata
);
  import hse_pkg::*;

  localparam int CW = AW + 2;

  typedef enum logic [12:0] {
    ST_LOAD = 13'b0000000000001,
    ST_RDN  = 13'b0000000000010,
    ST_LATN = 13'b0000000000100,
    ST_CHK  = 13'b0000000001000,
    ST_RDC1 = 13'b0000000010000,
    ST_RDC2 = 13'b0000000100000,
    ST_EXR0 = 13'b0000001000000,
    ST_EXRL = 13'b0000010000000,
    ST_EXWR = 13'b0000100000000,
    ST_DONE = 13'b0001000000000,
    ST_EMRD = 13'b0010000000000,
    ST_EMLD = 13'b0100000000000,
    ST_EMWT = 13'b1000000000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              drop_r, drop_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  hn_r, hn_nxt;
  logic [CNT_W-1:0]  bk_r, bk_nxt;
  logic [CNT_W-1:0]  ek_r, ek_nxt;
  logic [AW-1:0]     node_r, node_nxt;
  logic              phase_r, phase_nxt;
  val_t              nv_r, nv_nxt;
  val_t              cv_r, cv_nxt;
  val_t              od_r, od_nxt;
  logic              ol_r, ol_nxt;
  logic              ou_r, ou_nxt;

  logic [CW-1:0]     c_idx, c1_idx, hn_ext, bi;
  logic [CNT_W-1:0]  n_new, half;
  logic              right_ok;
  val_t              best;

  assign c_idx  = {1'b0, node_r, 1'b1};
  assign c1_idx = c_idx + CW'(1);
  assign hn_ext = CW'(hn_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    drop_nxt  = drop_r;
    n_nxt     = n_r;
    hn_nxt    = hn_r;
    bk_nxt    = bk_r;
    ek_nxt    = ek_r;
    node_nxt  = node_r;
    phase_nxt = phase_r;
    nv_nxt    = nv_r;
    cv_nxt    = cv_r;
    od_nxt    = od_r;
    ol_nxt    = ol_r;
    ou_nxt    = ou_r;
    mem_we    = 1'b0;
    mem_waddr = node_r;
    mem_wdata = nv_r;
    mem_raddr = node_r;
    n_new     = cnt_r;
    half      = '0;
    right_ok  = 1'b0;
    best      = cv_r;
    bi        = c_idx;
    case (state_r)
      ST_LOAD: begin
        if (in_tvalid) begin
          if (cnt_r < CNT_W'(DEPTH)) begin
            mem_we    = 1'b1;
            mem_waddr = cnt_r[AW-1:0];
            mem_wdata = in_value;
            n_new     = cnt_r + CNT_W'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          cnt_nxt = n_new;
          if (in_tlast) begin
            half      = n_new >> 1;
            n_nxt     = n_new;
            hn_nxt    = n_new;
            bk_nxt    = half;
            phase_nxt = 1'b0;
            if (half != '0) begin
              node_nxt  = AW'(half - CNT_W'(1));
              state_nxt = ST_RDN;
            end else begin
              state_nxt = ST_DONE;
            end
          end
        end
      end
      ST_RDN: begin
        mem_raddr = node_r;
        state_nxt = ST_LATN;
      end
      ST_LATN: begin
        nv_nxt    = mem_rdata;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (c_idx >= hn_ext) begin
          mem_we    = 1'b1;
          mem_waddr = node_r;
          mem_wdata = nv_r;
          state_nxt = ST_DONE;
        end else begin
          mem_raddr = c_idx[AW-1:0];
          state_nxt = ST_RDC1;
        end
      end
      ST_RDC1: begin
        mem_raddr = c1_idx[AW-1:0];
        cv_nxt    = mem_rdata;
        state_nxt = ST_RDC2;
      end
      ST_RDC2: begin
        right_ok = (c1_idx < hn_ext) && (mem_rdata > cv_r);
        best     = right_ok ? mem_rdata : cv_r;
        bi       = right_ok ? c1_idx : c_idx;
        mem_we    = 1'b1;
        mem_waddr = node_r;
        if (best > nv_r) begin
          mem_wdata = best;
          node_nxt  = bi[AW-1:0];
          state_nxt = ST_CHK;
        end else begin
          mem_wdata = nv_r;
          state_nxt = ST_DONE;
        end
      end
      ST_EXR0: begin
        mem_raddr = '0;
        state_nxt = ST_EXRL;
      end
      ST_EXRL: begin
        mem_raddr = AW'(hn_r - CNT_W'(1));
        cv_nxt    = mem_rdata;
        state_nxt = ST_EXWR;
      end
      ST_EXWR: begin
        nv_nxt    = mem_rdata;
        mem_we    = 1'b1;
        mem_waddr = AW'(hn_r - CNT_W'(1));
        mem_wdata = cv_r;
        hn_nxt    = hn_r - CNT_W'(1);
        node_nxt  = '0;
        state_nxt = ST_CHK;
      end
      ST_DONE: begin
        if (!phase_r && (bk_r > CNT_W'(1))) begin
          bk_nxt    = bk_r - CNT_W'(1);
          node_nxt  = AW'(bk_r - CNT_W'(2));
          state_nxt = ST_RDN;
        end else begin
          phase_nxt = 1'b1;
          if (hn_r > CNT_W'(1)) begin
            state_nxt = ST_EXR0;
          end else begin
            ek_nxt    = '0;
            state_nxt = ST_EMRD;
          end
        end
      end
      ST_EMRD: begin
        mem_raddr = ek_r[AW-1:0];
        state_nxt = ST_EMLD;
      end
      ST_EMLD: begin
        od_nxt    = mem_rdata;
        ol_nxt    = (ek_r + CNT_W'(1)) == n_r;
        ou_nxt    = drop_r;
        state_nxt = ST_EMWT;
      end
      ST_EMWT: begin
        if (out_tready) begin
          if (ol_r) begin
            cnt_nxt   = '0;
            drop_nxt  = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            ek_nxt    = ek_r + CNT_W'(1);
            state_nxt = ST_EMRD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    hn_r   <= hn_nxt;
    bk_r   <= bk_nxt;
    ek_r   <= ek_nxt;
    node_r <= node_nxt;
    nv_r   <= nv_nxt;
    cv_r   <= cv_nxt;
    od_r   <= od_nxt;
    ol_r   <= ol_nxt;
    ou_r   <= ou_nxt;
  end

  assign in_tready  = (state_r == ST_LOAD);
  assign out_tvalid = (state_r == ST_EMWT);
  assign out_value  = od_r;
  assign out_tlast  = ol_r;
  assign out_tuser  = ou_r;

endmodule

FILE: hw/rtl/heap_sort_engine_unit.sv
// Top level of the heap sort engine: store and sequencer.
// Usage:
//   The in_ channel carries one signed 32-bit element per transaction;
//   in_tlast marks the last element of a batch. Up to DEPTH elements are
//   kept; further ones are dropped and every result of that batch then
//   carries out_tuser (overflow) high.
//   After the closing transaction the block sorts the batch in place and
//   emits it on the out_ channel in ascending order, out_tlast on the
//   final element. It accepts no input from the closing transaction until
//   the last result is taken.
//   Operation: loading accepts one element per cycle. Sorting is a heapsort
//   on a memory with one read port and registered read data; each sift
//   level reads the left child, reads the right child, then compares and
//   writes back. A batch of n needs n / 2 build sifts and n - 1
//   extractions. Each result is read from the store and registered before
//   it is offered, and the next read waits until it is taken. A stalled
//   receiver holds the current result in the output register and pauses
//   the sequencer.
//   Reset (rst_n low, synchronous) clears the element count and the
//   overflow flag and returns the block to loading. No clearing pass.
module heap_sort_engine_unit #(
  parameter int DEPTH = hse_pkg::HSE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tlast,   // last_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] sorted_value
  output logic        out_tlast,  // last_out
  output logic        out_tuser   // [0] overflow
);
  import hse_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  val_t          mem_wdata;
  val_t          mem_rdata;
  val_t          out_value;

  hse_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  hse_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_value   (val_t'(in_tdata)),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_value  (out_value),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  assign out_tdata = out_value;

endmodule

FILE: test/heap_sort_checker.sv
// Checker for the heap sort engine: predicts each sorted batch and compares it with the output.
`timescale 1ns / 1ps

module heap_sort_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tlast,   // last_in
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [31:0] sorted_value
  input  logic        out_tlast,  // last_out
  input  logic        out_tuser,  // [0] overflow
  output int          pending,
  output int          fail_count
);
  import hse_pkg::*;

  typedef struct packed {
    val_t sorted_value;
    logic last_out;
    logic overflow;
  } sorted_item_t;

  sorted_item_t sorted_q[$];
  val_t         batch_mem[HSE_DEPTH];
  int           batch_len;
  logic         batch_dropped;
  int           errors;

  function automatic void sort_batch();
    val_t         held;
    int           j;
    sorted_item_t item;
    for (int i = 1; i < batch_len; i++) begin
      held = batch_mem[i];
      j = i - 1;
      while (j >= 0 && batch_mem[j] > held) begin
        batch_mem[j+1] = batch_mem[j];
        j--;
      end
      batch_mem[j+1] = held;
    end
    for (int k = 0; k < batch_len; k++) begin
      item.sorted_value = batch_mem[k];
      item.last_out     = (k == batch_len - 1);
      item.overflow     = batch_dropped;
      sorted_q.push_back(item);
    end
    batch_len     = 0;
    batch_dropped = 1'b0;
  endfunction

  initial begin
    batch_len     = 0;
    batch_dropped = 1'b0;
    errors        = 0;
  end

  always @(posedge clk) begin : watch
    sorted_item_t want;
    if (!rst_n) begin
      sorted_q.delete();
      batch_len     = 0;
      batch_dropped = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (sorted_q.size() == 0) begin
          $error("unexpected transaction: sorted_value %0d", $signed(out_tdata));
          errors++;
        end else begin
          want = sorted_q.pop_front();
          if (out_tdata !== want.sorted_value) begin
            $error("sorted_value: expected %0d, actual %0d",
                   want.sorted_value, $signed(out_tdata));
            errors++;
          end
          if (out_tlast !== want.last_out) begin
            $error("last_out: expected %0b, actual %0b", want.last_out, out_tlast);
            errors++;
          end
          if (out_tuser !== want.overflow) begin
            $error("overflow: expected %0b, actual %0b", want.overflow, out_tuser);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (batch_len < HSE_DEPTH) begin
          batch_mem[batch_len] = in_tdata;
          batch_len++;
        end else begin
          batch_dropped = 1'b1;
        end
        if (in_tlast)
          sort_batch();
      end
    end
    pending    <= sorted_q.size();
    fail_count <= errors;
  end

endmodule

FILE: test/testbench.sv
// Testbench top for the heap sort engine: clock, reset, batch stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import hse_pkg::*;

  typedef logic [31:0] word_q_t[$];

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [31:0] in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  int tx_idle = 0;
  int rx_idle = 0;
  int sent    = 0;
  int pending;
  int fail_count;

  always #4 clk = ~clk;

  heap_sort_engine_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  heap_sort_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle);
  end

  task automatic send_item(input logic [31:0] value, input logic last_in);
    while ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= last_in;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_list(input word_q_t values);
    foreach (values[i])
      send_item(values[i], i == values.size() - 1);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      case ($urandom_range(3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    if (pick < 35)
      return 32'($urandom_range(15)) - 32'd8;
    return $urandom;
  endfunction

  task automatic send_batch(input int len);
    for (int i = 0; i < len; i++)
      send_item(pick_value(), i == len - 1);
  endtask

  task automatic run_phase(input int tx, input int rx, input int quota);
    int pick;
    int len;
    tx_idle = tx;
    rx_idle = rx;
    while (sent < quota) begin
      pick = $urandom_range(99);
      if (pick < 80)
        len = $urandom_range(12, 1);
      else if (pick < 88)
        len = $urandom_range(HSE_DEPTH, HSE_DEPTH - 4);
      else
        len = $urandom_range(HSE_DEPTH + 6, HSE_DEPTH + 1);
      send_batch(len);
    end
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_list('{32'h8000_0000});
    send_list('{32'h7fff_ffff});
    send_list('{32'h7fff_ffff, 32'h8000_0000});
    send_list('{32'h0000_0000, 32'hffff_ffff, 32'h0000_0001});
    send_list('{32'h0000_0005, 32'h0000_0005, 32'h0000_0005, 32'hffff_fffb});
    send_list('{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                32'h8000_0000, 32'h7fff_ffff});
    send_list('{32'h0000_0008, 32'h0000_0007, 32'h0000_0006, 32'h0000_0005,
                32'h0000_0004, 32'h0000_0003, 32'h0000_0002, 32'h0000_0001});
    wait_drained();

    run_phase(38, 61, 150);
    run_phase(61, 38, 290);
    run_phase(0, 0, 420);

    repeat (500) @(posedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
